// ----- design/spr_pkg.sv -----
// shared widths, register indexes and direction codes for the speed ramp period unit
package spr_pkg;

    // payload widths
    localparam int SPEED_W  = 16;
    localparam int PERIOD_W = 24;
    localparam int ACCEL_W  = 15;
    localparam int DIR_W    = 2;
    localparam int MAG_W    = SPEED_W + 1;
    localparam int CFG_A_W  = 2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_SLEW_LIMIT  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_ZERO_PERIOD = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_FINE_STEP   = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_DIR_INVERT  = 2'd3;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REVERSE = 2'd2;

    // microstep scale factors
    localparam logic [6:0] SCALE_FINE   = 7'd50;
    localparam logic [6:0] SCALE_COARSE = 7'd25;

    // reset values of the registers
    localparam logic [ACCEL_W-1:0]  RST_SLEW_LIMIT  = 15'd14;
    localparam logic [PERIOD_W-1:0] RST_ZERO_PERIOD = 24'd65535;

endpackage

// ----- design/spr_div.sv -----
// restoring serial divider, one quotient bit per cycle
module spr_div
    import spr_pkg::*;
#(
    parameter int DIVIDEND_W = 21
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [MAG_W-1:0]      i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [MAG_W-1:0]  r_rem, n_rem;
    logic [MAG_W-1:0]  r_div, n_div;
    logic [MAG_W:0]    w_shift;
    logic [MAG_W+1:0]  w_trial;

    // shift in the next dividend bit and try the subtraction
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (w_trial[MAG_W+1]) begin
                n_rem = w_shift[MAG_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
            end else begin
                n_rem = w_trial[MAG_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- design/stepper_speed_ramp_period_unit.sv -----
// slew-limited stepper speed ramp with step timer period by serial division
//
//  channel   | dir | fields (lsb first)
//  s_axis    | in  | tdata: target_speed[15:0]
//  m_axis    | out | tdata: step_period[23:0] timer_enable[24] direction[26:25]
//            |     |        dir_pin_level[27] ramped_speed[43:28], zero fill to 48
//  cfg       | in  | i_cfg_we, i_cfg_addr, i_cfg_data[23:0]
//
// a running item passes IDLE, SCALE, DIV and OUT, one quotient bit per cycle for DW
// bits (DW = bits of TIMER_BASE_HZ, 21 at the default); a stopped item skips DIV
// reset clears the stored speed and loads the register defaults
// a new item is taken while a result waits; the result stalls inside the block
// until the output register is free, and no new item is taken meanwhile
module stepper_speed_ramp_period_unit
    import spr_pkg::*;
#(
    parameter int unsigned TIMER_BASE_HZ = 2000000,
    parameter int unsigned MIN_PERIOD    = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // target_speed[15:0]
    input  logic [15:0]         s_axis_tdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // step_period, timer_enable, direction, dir_pin_level, ramped_speed
    output logic [47:0]         m_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                i_cfg_we,
    input  logic [CFG_A_W-1:0]  i_cfg_addr,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    localparam int DW   = $clog2(TIMER_BASE_HZ + 1);
    localparam int CW   = (DW > PERIOD_W) ? DW : PERIOD_W;
    localparam int PW   = SPEED_W + 7;
    localparam logic [DW-1:0] BASE = DW'(TIMER_BASE_HZ);
    localparam logic [CW-1:0] MINP = CW'(MIN_PERIOD);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCALE = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]          r_state;
    logic [ACCEL_W-1:0]  r_slew_limit;
    logic [PERIOD_W-1:0] r_zero_period;
    logic                r_fine;
    logic                r_dir_inv;
    logic signed [SPEED_W-1:0] r_cur;
    logic [PERIOD_W-1:0] r_period;
    logic                r_enable;
    logic [DIR_W-1:0]    r_dir;
    logic                r_pin;
    logic [MAG_W-1:0]    r_mag;
    logic                r_out_valid;
    logic [47:0]         r_out_data;

    logic signed [SPEED_W:0]   w_diff;
    logic signed [SPEED_W:0]   w_acc;
    logic signed [SPEED_W-1:0] w_slew;
    logic signed [PW-1:0]      w_prod;
    logic signed [SPEED_W-1:0] w_sat;
    logic [MAG_W-1:0]          w_sext;
    logic [MAG_W-1:0]          w_mag;
    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_start;
    logic                      w_div_busy;
    logic                      w_div_done;
    logic [DW-1:0]             w_quo;
    logic [CW-1:0]             w_clamp_hi;
    logic [CW-1:0]             w_clamp;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_start    = (r_state == S_SCALE) && (w_sat != '0);

    // slew limit toward the target
    assign w_diff = {r_cur[SPEED_W-1], r_cur} - {s_axis_tdata[SPEED_W-1], s_axis_tdata};
    assign w_acc  = {2'b00, r_slew_limit};
    always_comb begin
        priority if (w_diff > w_acc) begin
            w_slew = SPEED_W'(r_cur - w_acc[SPEED_W-1:0]);
        end else if (w_diff < -w_acc) begin
            w_slew = SPEED_W'(r_cur + w_acc[SPEED_W-1:0]);
        end else begin
            w_slew = s_axis_tdata;
        end
    end

    // microstep scaling and saturation to 16-bit signed
    assign w_prod = r_cur * $signed(r_fine ? SCALE_FINE : SCALE_COARSE);
    always_comb begin
        priority if (w_prod > PW'(32767)) begin
            w_sat = 16'sh7FFF;
        end else if (w_prod < -PW'(32768)) begin
            w_sat = 16'sh8000;
        end else begin
            w_sat = w_prod[SPEED_W-1:0];
        end
    end
    assign w_sext = {w_sat[SPEED_W-1], w_sat};
    assign w_mag  = w_sat[SPEED_W-1] ? (~w_sext + 1'b1) : w_sext;

    spr_div #(
        .DIVIDEND_W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (BASE),
        .i_divisor  (w_mag),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // period clamp: upper bound first, lower bound wins
    assign w_clamp_hi = (CW'(w_quo) > CW'(r_zero_period)) ? CW'(r_zero_period) : CW'(w_quo);
    assign w_clamp    = (w_clamp_hi < MINP) ? MINP : w_clamp_hi;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_limit  <= RST_SLEW_LIMIT;
            r_zero_period <= RST_ZERO_PERIOD;
            r_fine        <= 1'b1;
            r_dir_inv     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SLEW_LIMIT:  r_slew_limit  <= i_cfg_data[ACCEL_W-1:0];
                REG_ZERO_PERIOD: r_zero_period <= i_cfg_data;
                REG_FINE_STEP:   r_fine        <= i_cfg_data[0];
                REG_DIR_INVERT:  r_dir_inv     <= i_cfg_data[0];
            endcase
        end
    end

    // sequencer and stored speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cur   <= w_slew;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state <= (w_sat == '0) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE) begin
            r_mag <= w_mag;
            if (w_sat == '0) begin
                r_period <= r_zero_period;
                r_enable <= 1'b0;
                r_dir    <= DIR_STOP;
                r_pin    <= 1'b0;
            end else begin
                r_enable <= 1'b1;
                r_dir    <= w_sat[SPEED_W-1] ? DIR_REVERSE : DIR_FORWARD;
                r_pin    <= !w_sat[SPEED_W-1] ^ r_dir_inv;
            end
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_period <= w_clamp[PERIOD_W-1:0];
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_data <= {4'b0000, r_cur, r_pin, r_dir, r_enable, r_period};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // divider runs only while the sequencer waits on it
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) && (r_state != S_SCALE) |-> !w_div_busy)
        else $error("divider busy outside the divide phase");

    // a divide never starts on a zero magnitude
    a_mag_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_mag != '0))
        else $error("divide started on zero speed");

    // a stopped result carries stop direction and a low pin
    a_stop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[24] |->
        (m_axis_tdata[26:25] == DIR_STOP) && !m_axis_tdata[27])
        else $error("stopped item with direction set");

endmodule

// ----- tb/sv/tb_stepper_speed_ramp_period_unit.sv -----
// self-checking testbench for the stepper speed ramp period unit
module tb_stepper_speed_ramp_period_unit;
    import spr_pkg::*;

    localparam int unsigned BASE_HZ     = 2000000;
    localparam int unsigned PERIOD_MIN  = 100;
    localparam int          DRAIN_WAIT  = 40;
    localparam int          CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic [15:0]           s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  i_cfg_we;
    logic [CFG_A_W-1:0]    i_cfg_addr;
    logic [PERIOD_W-1:0]   i_cfg_data;

    bit idle_on;
    int cycle_count;
    int stall_left;

    // one expected output item
    typedef struct {
        logic [PERIOD_W-1:0]       period;
        logic                      enable;
        logic [DIR_W-1:0]          dir;
        logic                      pin;
        logic signed [SPEED_W-1:0] speed;
    } step_rate_t;

    // ramp predictor and expected-item store
    class ramp_scoreboard;
        logic [ACCEL_W-1:0]        slew_limit;
        logic [PERIOD_W-1:0]       zero_period;
        bit                        fine_step;
        bit                        dir_invert;
        logic signed [SPEED_W-1:0] speed;
        step_rate_t                pending[$];
        int                        errors;

        function new();
            slew_limit  = RST_SLEW_LIMIT;
            zero_period = RST_ZERO_PERIOD;
            fine_step   = 1'b1;
            dir_invert  = 1'b0;
            speed       = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_A_W-1:0] addr, logic [PERIOD_W-1:0] data);
            case (addr)
                REG_SLEW_LIMIT:  slew_limit  = data[ACCEL_W-1:0];
                REG_ZERO_PERIOD: zero_period = data;
                REG_FINE_STEP:   fine_step   = data[0];
                REG_DIR_INVERT:  dir_invert  = data[0];
                default: ;
            endcase
        endfunction

        // slew toward the target, scale, saturate, then divide for the period
        function void note_target(logic signed [SPEED_W-1:0] target);
            int          cur;
            int          acc;
            int          diff;
            int          scaled;
            int unsigned mag;
            int unsigned quot;
            step_rate_t  r;
            cur  = speed;
            acc  = int'(slew_limit);
            diff = cur - int'(target);
            if (diff > acc) begin
                cur = cur - acc;
            end else if (diff < -acc) begin
                cur = cur + acc;
            end else begin
                cur = target;
            end
            speed  = cur[SPEED_W-1:0];
            scaled = cur * (fine_step ? int'(SCALE_FINE) : int'(SCALE_COARSE));
            if (scaled > 32767) scaled = 32767;
            if (scaled < -32768) scaled = -32768;
            r.speed = speed;
            if (scaled == 0) begin
                r.period = zero_period;
                r.enable = 1'b0;
                r.dir    = DIR_STOP;
                r.pin    = 1'b0;
            end else begin
                mag  = (scaled < 0) ? -scaled : scaled;
                quot = BASE_HZ / mag;
                if (quot > zero_period) quot = zero_period;
                if (quot < PERIOD_MIN) quot = PERIOD_MIN;
                r.period = quot[PERIOD_W-1:0];
                r.enable = 1'b1;
                r.dir    = (scaled > 0) ? DIR_FORWARD : DIR_REVERSE;
                r.pin    = (scaled > 0) ^ dir_invert;
            end
            pending.push_back(r);
        endfunction

        function void compare_field(string label, longint expv, longint actv);
            if (expv != actv) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, label, expv, actv);
            end
        endfunction

        function void check_output(logic [47:0] word);
            step_rate_t                r;
            logic signed [SPEED_W-1:0] act_speed;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected output item, expected none, actual %h",
                         $time, word);
                return;
            end
            r         = pending.pop_front();
            act_speed = word[43:28];
            compare_field("step_period", r.period, word[23:0]);
            compare_field("timer_enable", r.enable, word[24]);
            compare_field("direction", r.dir, word[26:25]);
            compare_field("dir_pin_level", r.pin, word[27]);
            compare_field("ramped_speed", r.speed, act_speed);
        endfunction
    endclass

    ramp_scoreboard board = new();

    stepper_speed_ramp_period_unit #(
        .TIMER_BASE_HZ (BASE_HZ),
        .MIN_PERIOD    (PERIOD_MIN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run-length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // output check on each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_output(m_axis_tdata);
        end
    end

    // receiver stalls in bursts while idling is on, else it is always ready
    always @(negedge i_clk) begin
        if (!idle_on) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // drive one target speed, with an optional gap before it
    task automatic send_target(input logic signed [15:0] target);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= target;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_target(target);
    endtask

    // stop sending and wait until every expected item has come back
    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    // write all four registers; the block must be idle
    task automatic apply_setting(input int accel, input int zero_per,
                                 input bit fine, input bit invert);
        logic [PERIOD_W-1:0] vals[4];
        logic [CFG_A_W-1:0]  addrs[4];
        wait_drain();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        addrs = '{REG_SLEW_LIMIT, REG_ZERO_PERIOD, REG_FINE_STEP, REG_DIR_INVERT};
        vals  = '{PERIOD_W'(accel), PERIOD_W'(zero_per), PERIOD_W'(fine),
                  PERIOD_W'(invert)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= addrs[k];
            i_cfg_data <= vals[k];
            board.set_reg(addrs[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_target();
        int v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 1400) - 700;
            2: v = $urandom_range(0, 2800) - 1400;
            3: begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            default: v = $urandom_range(0, 40) - 20;
        endcase
        return v[15:0];
    endfunction

    // mostly held targets so the speed ramps, with single noise items between
    task automatic run_ramps(input int count);
        int sent;
        int reps;
        logic signed [15:0] target;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 7) begin
                target = pick_target();
                reps   = $urandom_range(2, 12);
            end else begin
                target = 16'($urandom);
                reps   = 1;
            end
            repeat (reps) send_target(target);
            sent += reps;
            if ($urandom_range(0, 40) == 0) wait_drain();
        end
    endtask

    logic signed [15:0] directed_a[] = '{0, 5, 100, -100, -32768, -32768, 0};
    logic signed [15:0] directed_b[] = '{32767, -32768, -32768, 1, 1, -1, 0};
    logic signed [15:0] directed_c[] = '{1, 0, -1, -32768, 32767};

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_SLEW_LIMIT;
        i_cfg_data    = '0;
        idle_on       = 1'b1;
        cycle_count   = 0;
        stall_left    = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: slow ramp, stop, reverse
        foreach (directed_a[k]) send_target(directed_a[k]);
        // widest slew, top period: saturation, jump through zero, slowest period
        apply_setting(32767, 16777215, 1'b1, 1'b1);
        foreach (directed_b[k]) send_target(directed_b[k]);
        // upper clamp below the minimum period, coarse microstepping
        apply_setting(32767, 50, 1'b0, 1'b0);
        foreach (directed_c[k]) send_target(directed_c[k]);

        apply_setting(32767, 16777215, 1'b1, 1'b1);
        run_ramps(200);
        apply_setting(0, 100, 1'b0, 1'b0);
        run_ramps(40);
        apply_setting(1, 50, 1'b1, 1'b0);
        run_ramps(150);
        repeat (3) begin
            apply_setting($urandom_range(1, 64), $urandom_range(100, 200000),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            run_ramps(200);
        end
        apply_setting($urandom_range(64, 32767), $urandom_range(100, 16777215),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_ramps(150);

        // last part without idling on either side
        apply_setting(14, 65535, 1'b1, 1'b0);
        idle_on = 1'b0;
        run_ramps(150);

        wait_drain();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- stepper_speed_ramp_period_unit.f -----
design/spr_pkg.sv
design/spr_div.sv
design/stepper_speed_ramp_period_unit.sv
tb/sv/tb_stepper_speed_ramp_period_unit.sv
